@@ design/rangefinder_frame_parser_defines.svh @@
// ----------------------------------------------------------------------------
// Rangefinder frame parser assertion macros
// Shared property forms for the checkers that watch the parser's ports.
// ----------------------------------------------------------------------------
`ifndef RANGEFINDER_FRAME_PARSER_DEFINES_SVH
`define RANGEFINDER_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RFP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rangefinder frame parser check failed");

// Next-cycle implication, active through reset as well.
`define RFP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("rangefinder frame parser check failed");

`endif

@@ design/rfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Rangefinder frame parser package
// Types and frame constants shared by the parser and its checker.
// ----------------------------------------------------------------------------
package rfp_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] dist_t;
  typedef logic [3:0]  phase_t;

  localparam byte_t HEADER_BYTE = 8'h59;
  localparam int    FRAME_BYTES = 9;

  localparam phase_t PH_HUNT     = 4'd0;
  localparam phase_t PH_HEADER2  = 4'd1;
  localparam phase_t PH_DIST_LO  = 4'd2;
  localparam phase_t PH_DIST_HI  = 4'd3;
  localparam phase_t PH_TEMP_HI  = 4'd7;
  localparam phase_t PH_CHECKSUM = 4'd8;

endpackage

@@ design/rangefinder_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Rangefinder frame parser
// Recognizes 9-byte rangefinder frames in a serial byte stream and reports
// the distance of every frame whose checksum matches.
// ----------------------------------------------------------------------------
// Each received byte beat passes an input register, then the frame state
// update writes the output register; a byte can be taken every cycle while
// the output is not stalled, and a distance is registered once its checksum
// byte is processed. A frame is two 0x59 header bytes, distance low and high,
// strength low and high, temperature low and high, and a checksum equal to
// the 8-bit sum of the first eight bytes. A wrong second header byte or a
// bad checksum sends the parser back to hunting for a header; a wrong second
// header byte is not reused as a new first header. Input stalls only while a
// distance is held at the output and a byte is waiting to be processed.
module rangefinder_frame_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_ready,
  input  rfp_pkg::byte_t rx_byte,
  output logic          distance_valid,
  input  logic          distance_ready,
  output rfp_pkg::dist_t distance_cm
);
  import rfp_pkg::*;

  logic   in_valid;
  byte_t  in_byte;
  phase_t phase;
  phase_t phase_next;
  phase_t phase_eff;
  byte_t  running_sum;
  byte_t  running_sum_next;
  byte_t  dist_low_byte;
  byte_t  dist_low_byte_next;
  byte_t  dist_high_byte;
  byte_t  dist_high_byte_next;
  logic   frame_good;
  logic   process;

  assign process  = in_valid && (!distance_valid || distance_ready);
  assign rx_ready = !in_valid || process;

  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    dist_low_byte_next  = dist_low_byte;
    dist_high_byte_next = dist_high_byte;
    frame_good          = 1'b0;
    phase_eff           = (phase > PH_CHECKSUM) ? PH_HUNT : phase;
    case (phase_eff) inside
      PH_HUNT: begin
        if (in_byte == HEADER_BYTE) begin
          running_sum_next = in_byte;
          phase_next       = PH_HEADER2;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_HEADER2: begin
        if (in_byte == HEADER_BYTE) begin
          running_sum_next = running_sum + in_byte;
          phase_next       = PH_DIST_LO;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      [PH_DIST_LO:PH_TEMP_HI]: begin
        if (phase_eff == PH_DIST_LO) begin
          dist_low_byte_next = in_byte;
        end
        if (phase_eff == PH_DIST_HI) begin
          dist_high_byte_next = in_byte;
        end
        running_sum_next = running_sum + in_byte;
        phase_next       = phase_eff + 4'd1;
      end
      PH_CHECKSUM: begin
        frame_good = (in_byte == running_sum);
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      phase          <= PH_HUNT;
      running_sum    <= '0;
      dist_low_byte  <= '0;
      dist_high_byte <= '0;
      distance_valid <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) begin
        in_valid <= 1'b1;
      end else if (process) begin
        in_valid <= 1'b0;
      end
      if (process) begin
        phase          <= phase_next;
        running_sum    <= running_sum_next;
        dist_low_byte  <= dist_low_byte_next;
        dist_high_byte <= dist_high_byte_next;
      end
      if (process && frame_good) begin
        distance_valid <= 1'b1;
      end else if (distance_ready) begin
        distance_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      in_byte <= rx_byte;
    end
    if (process && frame_good) begin
      distance_cm <= {dist_high_byte, dist_low_byte};
    end
  end

endmodule

@@ design/rfp_checker.sv @@
// ----------------------------------------------------------------------------
// Rangefinder frame parser checker
// Port-level checks on the parser's handshakes and result spacing.
// ----------------------------------------------------------------------------
`include "rangefinder_frame_parser_defines.svh"

module rfp_checker (
  input logic           clk,
  input logic           rst,
  input logic           rx_valid,
  input logic           rx_ready,
  input logic           distance_valid,
  input logic           distance_ready,
  input rfp_pkg::dist_t distance_cm
);
  import rfp_pkg::*;

  logic       out_held;
  logic [3:0] beat_count;
  logic       new_result;

  // A result that was not taken last cycle is the same result still on show.
  assign new_result = distance_valid && !out_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_held   <= 1'b0;
      beat_count <= '0;
    end else begin
      out_held <= distance_valid && !distance_ready;
      if (new_result) begin
        beat_count <= {3'b000, rx_valid && rx_ready};
      end else if (rx_valid && rx_ready && beat_count != 4'hF) begin
        beat_count <= beat_count + 4'd1;
      end
    end
  end

  `RFP_ASSERT_NEXT(a_no_result_after_reset, rst, !distance_valid)
  `RFP_ASSERT_NEXT(a_result_holds, !rst && distance_valid && !distance_ready,
                   distance_valid && $stable(distance_cm))
  `RFP_ASSERT_NOW(a_stall_only_on_full_output, !rx_ready,
                  distance_valid && !distance_ready)
  `RFP_ASSERT_NOW(a_result_needs_frame, new_result,
                  beat_count >= 4'(FRAME_BYTES - 1))

endmodule

bind rangefinder_frame_parser rfp_checker u_rfp_checker (.*);
